>>> src/glyph_quad_generator_defines.svh
// Assertion macros shared by the glyph quad generator sources.
// Define ASSERT_OFF to compile the checks away.
`ifndef GLYPH_QUAD_GENERATOR_DEFINES_SVH
`define GLYPH_QUAD_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glyph quad generator: same-cycle check failed");

// Whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glyph quad generator: next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/gqg_pkg.sv
package gqg_pkg;

  // Fixed field widths.
  localparam int POS_W       = 20;
  localparam int TEX_W       = 13;
  localparam int ATLAS_W     = 12;
  localparam int CODE_W      = 8;
  localparam int CODE_SPAN   = 1 << CODE_W;
  // Exact positions before saturation: pen plus offset and size, each shifted
  // by at most eight fraction bits.
  localparam int WIDE_W      = 23;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int VERTS       = 6;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam pos_t  POS_MAX   = pos_t'({1'b0, {(POS_W-1){1'b1}}});
  localparam pos_t  POS_MIN   = pos_t'({1'b1, {(POS_W-1){1'b0}}});
  localparam wide_t POS_MAX_W = wide_t'(POS_MAX);
  localparam wide_t POS_MIN_W = wide_t'(POS_MIN);

  // Input beat.
  typedef struct packed {
    logic                   op;
    logic [CODE_W-1:0]      char_code;
    logic                   first;
    pos_t                   start_x;
    pos_t                   start_y;
    logic [ATLAS_W-1:0]     atlas_x;
    logic [ATLAS_W-1:0]     atlas_y;
    logic [7:0]             glyph_width;
    logic [7:0]             glyph_height;
    logic signed [7:0]      offset_x;
    logic signed [7:0]      offset_y;
    logic [7:0]             advance;
  } in_t;

  // Output beat.
  typedef struct packed {
    pos_t             pos_x;
    pos_t             pos_y;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic             missing;
    logic             last;
  } out_t;

  // One glyph table entry, 64 bits.
  typedef struct packed {
    logic [ATLAS_W-1:0] ax;
    logic [ATLAS_W-1:0] ay;
    logic [7:0]         w;
    logic [7:0]         h;
    logic signed [7:0]  ox;
    logic signed [7:0]  oy;
    logic [7:0]         adv;
  } glyph_t;

  // One placed character handed from the front end to the vertex sequencer.
  typedef struct packed {
    logic               missing;
    wide_t              x0;
    wide_t              y0;
    logic [7:0]         w;
    logic [7:0]         h;
    logic [ATLAS_W-1:0] ax;
    logic [ATLAS_W-1:0] ay;
  } quad_t;

  // Clamp an exact position to the signed output range.
  function automatic pos_t sat_pos(input wide_t v);
    pos_t r;
    if (v > POS_MAX_W) begin
      r = POS_MAX;
    end else if (v < POS_MIN_W) begin
      r = POS_MIN;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/gqg_front.sv
module gqg_front
  import gqg_pkg::*;
#(
  parameter int GLYPH_ENTRIES = 256,
  parameter int ATLAS_SIZE    = 4096,
  parameter int FRAC_BITS     = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  push_valid,
  input  logic  push_ready,
  output quad_t push_data
);

  // Only codes reachable by the code field need storage.
  localparam int Depth = (GLYPH_ENTRIES < CODE_SPAN) ? GLYPH_ENTRIES : CODE_SPAN;
  localparam int IdxW  = $clog2(Depth);
  localparam logic [ATLAS_W-1:0] AtlasMax = ATLAS_W'(ATLAS_SIZE - 1);

  glyph_t             glyph_mem [Depth];
  logic [Depth-1:0]   glyph_valid;
  glyph_t             rd_entry;
  glyph_t             wr_entry;
  logic [IdxW-1:0]    idx;
  logic               in_range;
  logic               accept;
  logic               wr_en;
  logic               rd_en;
  logic               push;

  logic               s1_valid;
  logic               s1_hit;
  logic               s1_first;
  pos_t               s1_start_x;
  pos_t               s1_start_y;

  pos_t               pen_x;
  pos_t               pen_y;
  pos_t               pen_x_next;
  pos_t               base_x;
  pos_t               base_y;
  wide_t              off_x;
  wide_t              off_y;
  wide_t              adv_p;

  // Accept a beat whenever the lookup stage is empty or draining.
  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid || push_ready;
  assign wr_en    = accept && (in_data.op == OP_WRITE);
  assign rd_en    = accept && (in_data.op == OP_PLACE);
  assign idx      = in_data.char_code[IdxW-1:0];
  assign in_range = 32'(in_data.char_code) < 32'(GLYPH_ENTRIES);
  assign push       = push_valid && push_ready;
  assign push_valid = s1_valid;

  // Table entry with the atlas corner clamped to the atlas.
  always_comb begin
    wr_entry.ax  = (32'(in_data.atlas_x) >= 32'(ATLAS_SIZE)) ? AtlasMax : in_data.atlas_x;
    wr_entry.ay  = (32'(in_data.atlas_y) >= 32'(ATLAS_SIZE)) ? AtlasMax : in_data.atlas_y;
    wr_entry.w   = in_data.glyph_width;
    wr_entry.h   = in_data.glyph_height;
    wr_entry.ox  = in_data.offset_x;
    wr_entry.oy  = in_data.offset_y;
    wr_entry.adv = in_data.advance;
  end

  // Glyph metrics memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      glyph_mem[idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= glyph_mem[idx];
    end
  end

  // Entry valid flags, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_valid <= '0;
    end else if (wr_en && in_range) begin
      glyph_valid[idx] <= 1'b1;
    end
  end

  // Lookup stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  // Lookup stage payload, captured with the memory read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_hit     <= in_range && glyph_valid[idx];
      s1_first   <= in_data.first;
      s1_start_x <= in_data.start_x;
      s1_start_y <= in_data.start_y;
    end
  end

  // Pen origin for this character and the quad's top-left corner.
  always_comb begin
    base_x     = s1_first ? s1_start_x : pen_x;
    base_y     = s1_first ? s1_start_y : pen_y;
    off_x      = wide_t'(rd_entry.ox) <<< FRAC_BITS;
    off_y      = wide_t'(rd_entry.oy) <<< FRAC_BITS;
    adv_p      = wide_t'(rd_entry.adv) << FRAC_BITS;
    pen_x_next = s1_hit ? sat_pos(wide_t'(base_x) + adv_p) : base_x;

    push_data.missing = !s1_hit;
    push_data.x0      = wide_t'(base_x) + off_x;
    push_data.y0      = wide_t'(base_y) + off_y;
    push_data.w       = rd_entry.w;
    push_data.h       = rd_entry.h;
    push_data.ax      = rd_entry.ax;
    push_data.ay      = rd_entry.ay;
  end

  // The pen moves when a character leaves the lookup stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (push) begin
      pen_x <= pen_x_next;
      pen_y <= base_y;
    end
  end

endmodule

>>> src/gqg_queue.sv
`include "glyph_quad_generator_defines.svh"

module gqg_queue
  import gqg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  quad_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output quad_t pop_data
);

  localparam logic [QUEUE_PTR_W:0] Full = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

  quad_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = count != Full;
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= Full)
  `ASSERT_NEXT(a_count_up, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)
  `ASSERT_NEXT(a_count_down, clk, rst, do_pop && !do_push, count == $past(count) - 1'b1)

endmodule

>>> src/gqg_back.sv
`include "glyph_quad_generator_defines.svh"

module gqg_back
  import gqg_pkg::*;
#(
  parameter int FRAC_BITS = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  pop_valid,
  output logic  pop_ready,
  input  quad_t pop_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  // Corner pattern of the vertex order a, b, c, a, c, d.
  localparam logic [VERTS-1:0] UseX1    = 6'b010110;
  localparam logic [VERTS-1:0] UseY1    = 6'b001011;
  localparam logic [2:0]       LastVert = 3'(VERTS - 1);

  logic             busy;
  logic [2:0]       k;
  logic             miss;
  pos_t             cx0;
  pos_t             cx1;
  pos_t             cy0;
  pos_t             cy1;
  logic [TEX_W-1:0] cu0;
  logic [TEX_W-1:0] cu1;
  logic [TEX_W-1:0] cv0;
  logic [TEX_W-1:0] cv1;
  logic             emit;
  logic             done;
  logic             load;
  wide_t            x1_wide;
  wide_t            y1_wide;
  out_t             vert;

  // A vertex goes out whenever the output register is free or draining.
  assign emit      = busy && (!out_valid || out_ready);
  assign done      = emit && (miss || (k == LastVert));
  assign pop_ready = !busy || done;
  assign load      = pop_valid && pop_ready;
  assign x1_wide   = pop_data.x0 + (wide_t'(pop_data.w) << FRAC_BITS);
  assign y1_wide   = pop_data.y0 + (wide_t'(pop_data.h) << FRAC_BITS);

  // Sequencer control: busy flag and vertex counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (load || done) begin
        k <= '0;
      end else if (emit) begin
        k <= k + 1'b1;
      end
    end
  end

  // Saturated corners of the quad being emitted.
  always_ff @(posedge clk) begin
    if (load) begin
      miss <= pop_data.missing;
      cx0  <= sat_pos(pop_data.x0);
      cx1  <= sat_pos(x1_wide);
      cy0  <= sat_pos(pop_data.y0);
      cy1  <= sat_pos(y1_wide);
      cu0  <= TEX_W'(pop_data.ax);
      cu1  <= TEX_W'(pop_data.ax) + TEX_W'(pop_data.w);
      cv0  <= TEX_W'(pop_data.ay);
      cv1  <= TEX_W'(pop_data.ay) + TEX_W'(pop_data.h);
    end
  end

  // Current vertex, or the single marker beat for a missing glyph.
  always_comb begin
    if (miss) begin
      vert.pos_x   = '0;
      vert.pos_y   = '0;
      vert.tex_u   = '0;
      vert.tex_v   = '0;
      vert.missing = 1'b1;
      vert.last    = 1'b1;
    end else begin
      vert.pos_x   = UseX1[k] ? cx1 : cx0;
      vert.pos_y   = UseY1[k] ? cy1 : cy0;
      vert.tex_u   = UseX1[k] ? cu1 : cu0;
      vert.tex_v   = UseY1[k] ? cv1 : cv0;
      vert.missing = 1'b0;
      vert.last    = k == LastVert;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= vert;
    end
  end

  `ASSERT_IMPLY(a_count_range, clk, rst, busy, k <= LastVert)
  `ASSERT_IMPLY(a_miss_single, clk, rst, busy && miss, k == '0)
  `ASSERT_IMPLY(a_miss_last, clk, rst, out_valid && out_data.missing, out_data.last)
  `ASSERT_NEXT(a_stay_busy, clk, rst, emit && !done, busy && (k == $past(k) + 1'b1))

endmodule

>>> src/glyph_quad_generator.sv
// Glyph quad generator. Input beats either load one glyph metrics entry
// (op write) or place one character at the pen (op place). A placed
// character produces six vertex beats a, b, c, a, c, d forming two
// triangles with saturated fixed-point screen positions and atlas texture
// coordinates, then the pen advances in x; a code with no loaded entry
// produces one beat with missing and last set. The glyph valid flags clear
// in the reset cycle itself, so no setup time is needed after reset. The
// vertex sequencer emits one vertex beat per cycle while out_ready does not
// stall the output, and table writes produce nothing. Input beats are
// taken every cycle while the four-entry character queue has room, so
// writes and lookups run ahead of the output. A placed character passes
// through the lookup stage, the character queue, the corner registers and
// the output register before its first vertex appears.
module glyph_quad_generator
  import gqg_pkg::*;
#(
  parameter int GLYPH_ENTRIES = 256,
  parameter int ATLAS_SIZE    = 4096,
  parameter int FRAC_BITS     = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic  push_valid;
  logic  push_ready;
  quad_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  quad_t pop_data;

  // Table, pen and lookup.
  gqg_front #(
    .GLYPH_ENTRIES (GLYPH_ENTRIES),
    .ATLAS_SIZE    (ATLAS_SIZE),
    .FRAC_BITS     (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Placed characters waiting for the sequencer.
  gqg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Vertex sequencer and output register.
  gqg_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sim/tb_glyph_quad_generator.sv
module tb_glyph_quad_generator
  import gqg_pkg::*;
;

  localparam int FRAC_BITS    = 4;
  localparam int ATLAS_SIZE   = 4096;
  localparam int PIXEL        = 1 << FRAC_BITS;
  localparam int TEX_MAX      = (1 << TEX_W) - 1;
  localparam int RANDOM_ITEMS = 470;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 20;
  localparam int PRINT_CAP    = 50;

  // Tracks the glyph table and the pen, and holds the vertices still owed by the block.
  class quad_layout_checker;
    glyph_t glyphs [CODE_SPAN];
    bit     loaded [CODE_SPAN];
    int     pen_x;
    int     pen_y;
    out_t   owed_vertices [$];
    int     mismatches;

    function new();
      foreach (loaded[i]) begin
        loaded[i] = 1'b0;
      end
      pen_x = 0;
      pen_y = 0;
      mismatches = 0;
    endfunction

    function int clamp_pos(int v);
      if (v > int'(POS_MAX)) begin
        return int'(POS_MAX);
      end
      if (v < int'(POS_MIN)) begin
        return int'(POS_MIN);
      end
      return v;
    endfunction

    function out_t vertex(int x, int y, int u, int v, bit is_last);
      out_t o;
      o.pos_x   = pos_t'(clamp_pos(x));
      o.pos_y   = pos_t'(clamp_pos(y));
      o.tex_u   = TEX_W'((u > TEX_MAX) ? TEX_MAX : u);
      o.tex_v   = TEX_W'((v > TEX_MAX) ? TEX_MAX : v);
      o.missing = 1'b0;
      o.last    = is_last;
      return o;
    endfunction

    // Append one expected beat at the tail of the owed list.
    function void owe(out_t v);
      owed_vertices.insert(owed_vertices.size(), v);
    endfunction

    // Apply one accepted input beat and queue the vertices it should produce.
    function void note_beat(in_t b);
      glyph_t g;
      out_t   miss;
      int     x0, y0, x1, y1, u0, u1, v0, v1;
      if (b.op == OP_WRITE) begin
        g.ax  = (b.atlas_x >= ATLAS_SIZE) ? ATLAS_W'(ATLAS_SIZE - 1) : b.atlas_x;
        g.ay  = (b.atlas_y >= ATLAS_SIZE) ? ATLAS_W'(ATLAS_SIZE - 1) : b.atlas_y;
        g.w   = b.glyph_width;
        g.h   = b.glyph_height;
        g.ox  = b.offset_x;
        g.oy  = b.offset_y;
        g.adv = b.advance;
        glyphs[b.char_code] = g;
        loaded[b.char_code] = 1'b1;
        return;
      end
      // A restart applies even when the glyph turns out to be missing.
      if (b.first) begin
        pen_x = $signed(b.start_x);
        pen_y = $signed(b.start_y);
      end
      if (!loaded[b.char_code]) begin
        miss = '0;
        miss.missing = 1'b1;
        miss.last = 1'b1;
        owe(miss);
        return;
      end
      g  = glyphs[b.char_code];
      x0 = pen_x + int'($signed(g.ox)) * PIXEL;
      y0 = pen_y + int'($signed(g.oy)) * PIXEL;
      x1 = x0 + int'(g.w) * PIXEL;
      y1 = y0 + int'(g.h) * PIXEL;
      u0 = int'(g.ax);
      u1 = int'(g.ax) + int'(g.w);
      v0 = int'(g.ay);
      v1 = int'(g.ay) + int'(g.h);
      // Two triangles: a, b, c then a, c, d.
      owe(vertex(x0, y1, u0, v1, 1'b0));
      owe(vertex(x1, y1, u1, v1, 1'b0));
      owe(vertex(x1, y0, u1, v0, 1'b0));
      owe(vertex(x0, y1, u0, v1, 1'b0));
      owe(vertex(x1, y0, u1, v0, 1'b0));
      owe(vertex(x0, y0, u0, v0, 1'b1));
      pen_x = clamp_pos(pen_x + int'(g.adv) * PIXEL);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
        $display("mismatch at %0t: %s", $time, what);
      end
    endtask

    // Compare one output beat with the oldest owed vertex.
    task check_vertex(out_t got);
      out_t want;
      if (owed_vertices.size() == 0) begin
        report_mismatch($sformatf("unexpected output beat %h", got));
        return;
      end
      want = owed_vertices.pop_front();
      if (got.pos_x !== want.pos_x) begin
        report_mismatch($sformatf("pos_x %0d, expected %0d", got.pos_x, want.pos_x));
      end
      if (got.pos_y !== want.pos_y) begin
        report_mismatch($sformatf("pos_y %0d, expected %0d", got.pos_y, want.pos_y));
      end
      if (got.tex_u !== want.tex_u) begin
        report_mismatch($sformatf("tex_u %0d, expected %0d", got.tex_u, want.tex_u));
      end
      if (got.tex_v !== want.tex_v) begin
        report_mismatch($sformatf("tex_v %0d, expected %0d", got.tex_v, want.tex_v));
      end
      if (got.missing !== want.missing) begin
        report_mismatch($sformatf("missing %b, expected %b", got.missing, want.missing));
      end
      if (got.last !== want.last) begin
        report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
      end
    endtask

    function int owed();
      return owed_vertices.size();
    endfunction

    task check_drained();
      if (owed_vertices.size() != 0) begin
        report_mismatch($sformatf("%0d vertices never arrived", owed_vertices.size()));
      end
    endtask
  endclass

  logic clk;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  quad_layout_checker layout_chk = new();
  logic [7:0] loaded_codes [$];
  bit send_calm = 1'b0;

  glyph_quad_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every field random; callers override what matters.
  function automatic in_t random_beat();
    in_t b;
    b.op           = 1'($urandom);
    b.char_code    = 8'($urandom);
    b.first        = 1'($urandom);
    b.start_x      = pos_t'($urandom);
    b.start_y      = pos_t'($urandom);
    b.atlas_x      = ATLAS_W'($urandom);
    b.atlas_y      = ATLAS_W'($urandom);
    b.glyph_width  = 8'($urandom);
    b.glyph_height = 8'($urandom);
    b.offset_x     = 8'($urandom);
    b.offset_y     = 8'($urandom);
    b.advance      = 8'($urandom);
    return b;
  endfunction

  function automatic in_t write_beat(logic [7:0] code, int ax, int ay, int w, int h,
                                     int ox, int oy, int adv);
    in_t b;
    b              = random_beat();
    b.op           = OP_WRITE;
    b.char_code    = code;
    b.atlas_x      = ATLAS_W'(ax);
    b.atlas_y      = ATLAS_W'(ay);
    b.glyph_width  = 8'(w);
    b.glyph_height = 8'(h);
    b.offset_x     = 8'(ox);
    b.offset_y     = 8'(oy);
    b.advance      = 8'(adv);
    return b;
  endfunction

  function automatic in_t place_beat(logic [7:0] code, bit restart, int sx, int sy);
    in_t b;
    b           = random_beat();
    b.op        = OP_PLACE;
    b.char_code = code;
    b.first     = restart;
    b.start_x   = pos_t'(sx);
    b.start_y   = pos_t'(sy);
    return b;
  endfunction

  // Mostly pens near the origin, sometimes anywhere in the range.
  function automatic int random_start();
    if ($urandom_range(0, 3) == 0) begin
      return int'($signed(pos_t'($urandom)));
    end
    return int'($urandom_range(0, 131071)) - 65536;
  endfunction

  function automatic int unsigned next_gap();
    int unsigned roll;
    if (send_calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Offer one input beat, hold it until accepted, then maybe idle.
  task automatic send_beat(in_t beat);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    if (beat.op == OP_WRITE && !layout_chk.loaded[beat.char_code]) begin
      loaded_codes.insert(loaded_codes.size(), beat.char_code);
    end
    layout_chk.note_beat(beat);
    gap = next_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every owed vertex is out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (layout_chk.owed() != 0) begin
      @(posedge clk);
    end
  endtask

  // Output side: random stalls, with calm stretches of steady ready.
  int unsigned stall_left = 0;
  int unsigned phase_left = 0;
  bit          recv_calm  = 1'b0;

  always @(posedge clk) begin
    if (phase_left == 0) begin
      recv_calm  = ($urandom_range(0, 3) == 0);
      phase_left = $urandom_range(50, 300);
    end else begin
      phase_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!recv_calm && $urandom_range(0, 4) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check every accepted output beat.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      layout_chk.check_vertex(out_data);
    end
  end

  // Stop a hung run: count cycles in which no beat moves on either side.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_t         beat;
    int unsigned sent;
    int unsigned roll;
    int unsigned run_len;
    logic [7:0]  code;
    bit          pressure_done;
    sent = 0;
    pressure_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, field extremes, saturation both ways, restart on a miss.
    send_beat(place_beat(8'd65, 1'b1, 0, 0));
    send_beat(write_beat(8'd0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(write_beat(8'd255, 4095, 4095, 255, 255, 127, 127, 255));
    send_beat(write_beat(8'd128, 4095, 0, 255, 1, -128, -128, 1));
    send_beat(place_beat(8'd0, 1'b1, 0, 0));
    send_beat(place_beat(8'd255, 1'b0, 0, 0));
    send_beat(place_beat(8'd255, 1'b1, int'(POS_MAX), int'(POS_MAX)));
    send_beat(place_beat(8'd255, 1'b0, 0, 0));
    send_beat(place_beat(8'd128, 1'b1, int'(POS_MIN), int'(POS_MIN)));
    send_beat(place_beat(8'd128, 1'b0, 0, 0));
    send_beat(place_beat(8'd77, 1'b1, 12345, -5000));
    send_beat(place_beat(8'd0, 1'b0, 0, 0));
    send_beat(write_beat(8'd77, 100, 200, 10, 12, -3, 5, 9));
    send_beat(place_beat(8'd77, 1'b0, 0, 0));
    send_beat(place_beat(8'd77, 1'b0, 0, 0));
    send_beat(write_beat(8'd255, 1, 2, 3, 4, 0, -1, 0));
    send_beat(place_beat(8'd255, 1'b1, -16, -16));
    send_beat(place_beat(8'd200, 1'b0, 0, 0));
    send_beat(write_beat(8'd1, 2048, 2048, 128, 128, 64, -64, 128));
    send_beat(place_beat(8'd1, 1'b1, int'(POS_MAX) - 100, 0));
    send_beat(place_beat(8'd1, 1'b0, 0, 0));
    wait_drained();

    // Random: mostly strings of loaded glyphs, some table writes and some noise.
    while (sent < RANDOM_ITEMS) begin
      send_calm = ($urandom_range(0, 4) == 0);
      if (!pressure_done && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        pressure_done = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 75 && loaded_codes.size() != 0) begin
        run_len = $urandom_range(1, 12);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            code = 8'($urandom);
          end else begin
            code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
          end
          beat = place_beat(code, (i == 0) || ($urandom_range(0, 19) == 0),
                            random_start(), random_start());
          send_beat(beat);
          sent++;
        end
      end else if (roll < 90) begin
        run_len = $urandom_range(1, 6);
        for (int i = 0; i < run_len; i++) begin
          beat = random_beat();
          beat.op = OP_WRITE;
          send_beat(beat);
          sent++;
        end
      end else begin
        send_beat(random_beat());
        sent++;
      end
    end

    // Let the last vertices drain, then allow for anything extra.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    layout_chk.check_drained();
    if (layout_chk.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
